[hw/rtl/mbl_pkg.sv]
package mbl_pkg;

	localparam int ENTRIES = 32;
	localparam int ID_W = 5;
	localparam int CNT_W = 16;
	localparam int TOT_W = 20;
	localparam int SZ_W = 13;
	localparam int LEN_W = 6;

	localparam logic [SZ_W-1:0] MAX_OBJECT_PAGES = 13'd4096;
	localparam logic [TOT_W-1:0] TOTAL_MAX = 20'hFFFFF;
	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [TOT_W-1:0] BUDGET_RESET = 20'd256;

	typedef enum logic [1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_FREE    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_NEW       = 3'd0,
		ST_ALREADY   = 3'd1,
		ST_OVER      = 3'd2,
		ST_UNDERFLOW = 3'd3,
		ST_DONE      = 3'd4
	} status_t;

	localparam logic KIND_EVICT = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHK,
		S_EVICT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic            push;
		logic            remove;
		logic            pop;
		logic [ID_W-1:0] id;
	} lru_cmd_t;

endpackage

[hw/rtl/mbl_alu.sv]
module mbl_alu (
	input  logic [mbl_pkg::TOT_W-1:0] a,
	input  logic [mbl_pkg::TOT_W-1:0] b,
	input  logic                      sub,
	input  logic [mbl_pkg::TOT_W-1:0] budget,
	output logic [mbl_pkg::TOT_W-1:0] res,
	output logic                      over
);
	import mbl_pkg::*;

	logic [TOT_W:0] sum;

	always_comb begin
		sum = {1'b0, a} + {1'b0, b};
		over = sum > {1'b0, budget};
		if (sub) begin
			res = (a >= b) ? a - b : '0;
		end else begin
			res = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
		end
	end

endmodule

[hw/rtl/mbl_lru.sv]
module mbl_lru (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mbl_pkg::lru_cmd_t         op,
	output logic [mbl_pkg::ID_W-1:0]  head,
	output logic [mbl_pkg::LEN_W-1:0] len
);
	import mbl_pkg::*;

	logic [ID_W-1:0] order_q [ENTRIES];
	logic [LEN_W-1:0] len_q;
	logic [ENTRIES-1:0] hit;
	logic [ENTRIES-1:0] shift;

	// shift[j]: entry j takes its successor (at or after the removed slot)
	always_comb begin
		for (int j = 0; j < ENTRIES; j++) begin
			hit[j] = (LEN_W'(j) < len_q) && (op.pop ? (j == 0) : (order_q[j] == op.id));
		end
		shift[0] = hit[0];
		for (int j = 1; j < ENTRIES; j++) begin
			shift[j] = shift[j-1] | hit[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < ENTRIES; j++) begin
			if ((op.remove || op.pop) && shift[j] && j + 1 < ENTRIES) begin
				order_q[j] <= order_q[(j + 1) % ENTRIES];
			end else if (op.push && len_q == LEN_W'(j)) begin
				order_q[j] <= op.id;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if ((op.remove || op.pop) && shift[ENTRIES-1]) begin
			len_q <= len_q - 1'b1;
		end else if (op.push && len_q < LEN_W'(ENTRIES)) begin
			len_q <= len_q + 1'b1;
		end
	end

	assign head = order_q[0];
	assign len = len_q;

endmodule

[hw/rtl/mapping_budget_lru.sv]
// channel   signals                                           accepted when
// command   start, cmd, object_id, size_pages                 start && !busy
// result    result_valid, kind, result_object, status,
//           in_use_total, use_count_out, last                 result_valid (one cycle)
// config    cfg_we, cfg_wdata (budget_pages)                  cfg_we
//
// states chk, then evict and chk per eviction, then fin: the shared add/subtract unit
// tests total plus size against the budget in chk; evict pops the lru head.
// busy is high from the cycle after start until the final item is shown.
// reset clears mapped flags, use counts, lru length, page total; budget back to 256.
// results cannot be held off, so nothing in the block waits on the receiver.
module mapping_budget_lru (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                cmd,
	input  logic [mbl_pkg::ID_W-1:0]  object_id,
	input  logic [mbl_pkg::SZ_W-1:0]  size_pages,
	input  logic                      cfg_we,
	input  logic [mbl_pkg::TOT_W-1:0] cfg_wdata,
	output logic                      result_valid,
	output logic                      kind,
	output logic [mbl_pkg::ID_W-1:0]  result_object,
	output logic [2:0]                status,
	output logic [mbl_pkg::TOT_W-1:0] in_use_total,
	output logic [mbl_pkg::CNT_W-1:0] use_count_out,
	output logic                      last
);
	import mbl_pkg::*;

	state_t state_q, state_d;

	cmd_t cmd_q;
	logic [ID_W-1:0] id_q;
	logic [SZ_W-1:0] sz_q;
	logic [TOT_W-1:0] budget_q;
	logic [TOT_W-1:0] total_q;

	logic mapped_q [ENTRIES];
	logic [CNT_W-1:0] count_q [ENTRIES];
	logic [SZ_W-1:0] esize_q [ENTRIES];

	logic valid_q;
	logic kind_q;
	logic [ID_W-1:0] obj_q;
	status_t status_q;
	logic [TOT_W-1:0] tot_out_q;
	logic [CNT_W-1:0] cnt_out_q;
	logic last_q;

	logic bad;
	logic cur_mapped;
	logic [CNT_W-1:0] cur_cnt;
	logic [CNT_W-1:0] new_cnt;
	status_t fin_status;
	logic [SZ_W-1:0] sz_in;

	logic alu_sub;
	logic [TOT_W-1:0] alu_b;
	logic [TOT_W-1:0] alu_res;
	logic alu_over;

	lru_cmd_t lru_op;
	logic [ID_W-1:0] lru_head;
	logic [LEN_W-1:0] lru_len;

	mbl_alu u_alu (
		.a      (total_q),
		.b      (alu_b),
		.sub    (alu_sub),
		.budget (budget_q),
		.res    (alu_res),
		.over   (alu_over)
	);

	mbl_lru u_lru (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (lru_op),
		.head   (lru_head),
		.len    (lru_len)
	);

	assign bad = ({1'b0, id_q} >= LEN_W'(ENTRIES)) || (cmd_q == CMD_NONE);
	assign cur_mapped = mapped_q[id_q];
	assign cur_cnt = count_q[id_q];

	always_comb begin
		if (size_pages == '0) begin
			sz_in = SZ_W'(1);
		end else if (size_pages > MAX_OBJECT_PAGES) begin
			sz_in = MAX_OBJECT_PAGES;
		end else begin
			sz_in = size_pages;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_CHK;
			end
			S_CHK: begin
				if (bad) begin
					state_d = S_IDLE;
				end else if (cmd_q == CMD_ACQUIRE && !cur_mapped && alu_over
						&& lru_len != '0) begin
					state_d = S_EVICT;
				end else begin
					state_d = S_FIN;
				end
			end
			S_EVICT: state_d = S_CHK;
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		alu_sub = 1'b0;
		alu_b = TOT_W'(sz_q);
		lru_op = '0;
		lru_op.id = id_q;
		new_cnt = cur_cnt;
		fin_status = ST_DONE;
		unique case (cmd_q)
			CMD_ACQUIRE: begin
				new_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
				fin_status = cur_mapped ? ST_ALREADY : (alu_over ? ST_OVER : ST_NEW);
			end
			CMD_RELEASE: begin
				new_cnt = (cur_cnt == '0) ? cur_cnt : cur_cnt - 1'b1;
				fin_status = (cur_cnt == '0) ? ST_UNDERFLOW : ST_DONE;
			end
			default: begin
				new_cnt = '0;
				fin_status = ST_DONE;
			end
		endcase
		unique case (state_q)
			S_EVICT: begin
				alu_sub = 1'b1;
				alu_b = TOT_W'(esize_q[lru_head]);
				lru_op.pop = 1'b1;
			end
			S_FIN: begin
				unique case (cmd_q)
					CMD_ACQUIRE: lru_op.remove = cur_mapped && cur_cnt == '0;
					CMD_RELEASE: lru_op.push = cur_mapped && cur_cnt == CNT_W'(1);
					CMD_FREE: begin
						alu_sub = 1'b1;
						alu_b = TOT_W'(esize_q[id_q]);
						lru_op.remove = cur_mapped;
					end
					default: lru_op = lru_op;
				endcase
			end
			default: alu_sub = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			budget_q <= BUDGET_RESET;
			total_q <= '0;
			valid_q <= 1'b0;
			for (int j = 0; j < ENTRIES; j++) begin
				mapped_q[j] <= 1'b0;
				count_q[j] <= '0;
			end
		end else begin
			state_q <= state_d;
			valid_q <= 1'b0;
			if (cfg_we) budget_q <= cfg_wdata;
			if (state_q == S_CHK && bad) valid_q <= 1'b1;
			if (state_q == S_EVICT) begin
				valid_q <= 1'b1;
				mapped_q[lru_head] <= 1'b0;
				total_q <= alu_res;
			end
			if (state_q == S_FIN) begin
				valid_q <= 1'b1;
				count_q[id_q] <= new_cnt;
				if (cmd_q == CMD_ACQUIRE && !cur_mapped) begin
					mapped_q[id_q] <= 1'b1;
					total_q <= alu_res;
				end
				if (cmd_q == CMD_FREE && cur_mapped) begin
					mapped_q[id_q] <= 1'b0;
					total_q <= alu_res;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd_t'(cmd);
			id_q <= object_id;
			sz_q <= sz_in;
		end
		if (state_q == S_FIN && cmd_q == CMD_ACQUIRE && !cur_mapped) begin
			esize_q[id_q] <= sz_q;
		end
		if (state_q == S_CHK && bad) begin
			kind_q <= KIND_FINAL;
			obj_q <= id_q;
			status_q <= ST_DONE;
			tot_out_q <= total_q;
			cnt_out_q <= '0;
			last_q <= 1'b1;
		end
		if (state_q == S_EVICT) begin
			kind_q <= KIND_EVICT;
			obj_q <= lru_head;
			status_q <= ST_DONE;
			tot_out_q <= alu_res;
			cnt_out_q <= '0;
			last_q <= 1'b0;
		end
		if (state_q == S_FIN) begin
			kind_q <= KIND_FINAL;
			obj_q <= id_q;
			status_q <= fin_status;
			tot_out_q <= ((cmd_q == CMD_ACQUIRE || cmd_q == CMD_FREE) && (cmd_q == CMD_FREE
				? cur_mapped : !cur_mapped)) ? alu_res : total_q;
			cnt_out_q <= new_cnt;
			last_q <= 1'b1;
		end
	end

	assign busy = state_q != S_IDLE;
	assign result_valid = valid_q;
	assign kind = kind_q;
	assign result_object = obj_q;
	assign status = status_q;
	assign in_use_total = tot_out_q;
	assign use_count_out = cnt_out_q;
	assign last = last_q;

endmodule

[hw/rtl/mbl_checker.sv]
module mbl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_valid,
	input logic       kind,
	input logic [2:0] status,
	input logic       last
);
	import mbl_pkg::*;

	// the final item shows as the block goes idle again
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy) else $error("final item while busy");

	// eviction reports come mid-command
	a_evict_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy) else $error("eviction report while idle");

	a_evict_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> kind == KIND_EVICT && status == ST_DONE)
		else $error("bad eviction report fields");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !result_valid) else $error("accept not followed by busy");

endmodule

bind mapping_budget_lru mbl_checker u_mbl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.kind         (kind),
	.status       (status),
	.last         (last)
);

[dv/mapping_budget_lru_tb.sv]
import mbl_pkg::*;

class budget_lru_scoreboard;
	typedef struct {
		bit         kind;
		bit [4:0]   obj;
		bit [2:0]   st;
		bit [19:0]  tot;
		bit [15:0]  cnt;
		bit         last;
	} outcome_t;

	outcome_t   pending[$];
	int         errors;
	int         outcomes_seen;
	int         evictions_seen;
	bit [19:0]  budget;
	bit         mapped[ENTRIES];
	bit [15:0]  uses[ENTRIES];
	bit [12:0]  pages[ENTRIES];
	bit [4:0]   lru[$];
	bit [19:0]  total;

	function new();
		budget = BUDGET_RESET;
		total = '0;
		errors = 0;
		outcomes_seen = 0;
		evictions_seen = 0;
		foreach (mapped[i]) begin
			mapped[i] = 1'b0;
			uses[i] = '0;
		end
	endfunction

	function void add_outcome(bit k, bit [4:0] o, bit [2:0] s, bit [15:0] c, bit l);
		outcome_t e;
		e.kind = k;
		e.obj = o;
		e.st = s;
		e.tot = total;
		e.cnt = c;
		e.last = l;
		pending.push_back(e);
	endfunction

	function void lru_drop(bit [4:0] id);
		foreach (lru[i]) begin
			if (lru[i] == id) begin
				lru.delete(i);
				return;
			end
		end
	endfunction

	function void unmap(bit [4:0] id);
		mapped[id] = 1'b0;
		total = (total >= pages[id]) ? total - pages[id] : '0;
	endfunction

	// works out every result that one accepted item causes
	function void note_item(logic [1:0] c, logic [4:0] id, logic [12:0] size);
		int s;
		bit [4:0] v;
		status_t stt;
		stt = ST_DONE;
		if (c == CMD_NONE) begin
			add_outcome(KIND_FINAL, id, ST_DONE, '0, 1'b1);
			return;
		end
		if (c == CMD_ACQUIRE) begin
			if (mapped[id]) begin
				if (uses[id] == 0)
					lru_drop(id);
				stt = ST_ALREADY;
			end else begin
				s = size;
				if (s == 0)
					s = 1;
				if (s > MAX_OBJECT_PAGES)
					s = MAX_OBJECT_PAGES;
				while (int'(total) + s > int'(budget) && lru.size() > 0) begin
					v = lru.pop_front();
					unmap(v);
					add_outcome(KIND_EVICT, v, ST_DONE, '0, 1'b0);
				end
				stt = (int'(total) + s > int'(budget)) ? ST_OVER : ST_NEW;
				mapped[id] = 1'b1;
				pages[id] = 13'(s);
				total = (int'(total) + s > TOTAL_MAX) ? TOTAL_MAX : 20'(int'(total) + s);
			end
			if (uses[id] != COUNT_MAX)
				uses[id]++;
		end else if (c == CMD_RELEASE) begin
			if (uses[id] == 0) begin
				stt = ST_UNDERFLOW;
			end else begin
				uses[id]--;
				if (uses[id] == 0 && mapped[id] && lru.size() < ENTRIES)
					lru.push_back(id);
			end
		end else begin
			if (mapped[id]) begin
				lru_drop(id);
				unmap(id);
			end
			uses[id] = '0;
		end
		add_outcome(KIND_FINAL, id, stt, uses[id], 1'b1);
	endfunction

	function void check_result(bit k, bit [4:0] o, bit [2:0] s, bit [19:0] t,
			bit [15:0] c, bit l);
		outcome_t e;
		outcomes_seen++;
		if (k == KIND_EVICT)
			evictions_seen++;
		if (pending.size() == 0) begin
			$error("result with nothing expected: object %0d kind %0d", o, k);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (k !== e.kind) begin
			$error("kind exp %0d got %0d", e.kind, k);
			errors++;
		end
		if (o !== e.obj) begin
			$error("result_object exp %0d got %0d", e.obj, o);
			errors++;
		end
		if (s !== e.st) begin
			$error("status exp %0d got %0d", e.st, s);
			errors++;
		end
		if (t !== e.tot) begin
			$error("in_use_total exp %0d got %0d", e.tot, t);
			errors++;
		end
		if (c !== e.cnt) begin
			$error("use_count_out exp %0d got %0d", e.cnt, c);
			errors++;
		end
		if (l !== e.last) begin
			$error("last exp %0d got %0d", e.last, l);
			errors++;
		end
	endfunction
endclass

module mapping_budget_lru_tb;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE = 80;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         cmd = CMD_ACQUIRE;
	logic [ID_W-1:0]    object_id = '0;
	logic [SZ_W-1:0]    size_pages = 13'd1;
	logic               cfg_we = 1'b0;
	logic [TOT_W-1:0]   cfg_wdata = '0;
	logic               result_valid;
	logic               kind;
	logic [ID_W-1:0]    result_object;
	logic [2:0]         status;
	logic [TOT_W-1:0]   in_use_total;
	logic [CNT_W-1:0]   use_count_out;
	logic               last;

	budget_lru_scoreboard sb = new();
	int  cycles = 0;
	int  items_sent = 0;
	bit  quiet = 1'b0;

	mapping_budget_lru DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.object_id(object_id), .size_pages(size_pages), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .result_valid(result_valid), .kind(kind),
		.result_object(result_object), .status(status), .in_use_total(in_use_total),
		.use_count_out(use_count_out), .last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_item(cmd, object_id, size_pages);
			if (result_valid)
				sb.check_result(kind, result_object, status, in_use_total,
					use_count_out, last);
		end
	end

	// holds the item until the block takes it, then maybe leaves a gap
	task automatic send(logic [1:0] c, logic [4:0] id, logic [12:0] size);
		start <= 1'b1;
		cmd <= c;
		object_id <= id;
		size_pages <= size;
		do @(posedge clk); while (busy !== 1'b0);
		items_sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0 || busy !== 1'b0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_budget(logic [19:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.budget = v;
	endtask

	function automatic logic [12:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return 13'd0;
		if (r < 11)
			return 13'($urandom_range(4097, 8191));
		if (r < 20)
			return 13'($urandom_range(1000, 4096));
		return 13'($urandom_range(1, 48));
	endfunction

	task automatic random_part(int n);
		int k;
		int r;
		logic [4:0] id;
		logic [1:0] c;
		while (n > 0) begin
			id = 5'($urandom_range(0, ENTRIES - 1));
			if ($urandom_range(0, 9) < 7) begin
				// acquire a few times, release as many, so the object may join the lru
				k = $urandom_range(1, 3);
				repeat (k) send(CMD_ACQUIRE, id, pick_size());
				repeat (k) send(CMD_RELEASE, id, pick_size());
				n -= 2 * k;
			end else begin
				r = $urandom_range(0, 99);
				c = (r < 40) ? CMD_ACQUIRE : (r < 75) ? CMD_RELEASE :
					(r < 95) ? CMD_FREE : CMD_NONE;
				send(c, id, pick_size());
				n--;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset budget, eviction order, over budget, underflow, free cases
		send(CMD_RELEASE, 5'd0, 13'd1);
		send(CMD_ACQUIRE, 5'd0, 13'd0);
		send(CMD_ACQUIRE, 5'd31, 13'd100);
		send(CMD_ACQUIRE, 5'd31, 13'd7);
		send(CMD_RELEASE, 5'd31, 13'd7);
		send(CMD_RELEASE, 5'd31, 13'd7);
		send(CMD_RELEASE, 5'd0, 13'd7);
		send(CMD_ACQUIRE, 5'd10, 13'd155);
		send(CMD_RELEASE, 5'd10, 13'd1);
		send(CMD_ACQUIRE, 5'd21, 13'd8191);
		send(CMD_FREE, 5'd21, 13'd0);
		send(CMD_FREE, 5'd21, 13'd0);
		send(CMD_NONE, 5'd3, 13'h1555);
		send(CMD_ACQUIRE, 5'd4, 13'd4096);
		send(CMD_ACQUIRE, 5'd5, 13'd4097);
		send(CMD_RELEASE, 5'd4, 13'd0);
		send(CMD_FREE, 5'd5, 13'd0);
		send(CMD_FREE, 5'd4, 13'h0AAA);
		write_budget(20'd0);
		send(CMD_ACQUIRE, 5'd6, 13'd1);
		send(CMD_RELEASE, 5'd6, 13'd1);
		send(CMD_ACQUIRE, 5'd7, 13'd2);
		write_budget(20'hFFFFF);

		random_part(80);
		write_budget(BUDGET_RESET);
		random_part(140);
		drain();
		random_part(60);
		write_budget(20'($urandom_range(100, 2000)));
		random_part(80);
		write_budget(20'd0);
		random_part(30);
		write_budget(20'd300);
		quiet = 1'b1;
		random_part(70);
		drain();

		$display("covered %0d items, %0d results, %0d evictions, budgets 0 to max",
			items_sent, sb.outcomes_seen, sb.evictions_seen);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
